// ===== design/matrix4_inverse_assert.svh =====
// Assertion macros shared by the matrix inverse RTL.
`ifndef MATRIX4_INVERSE_ASSERT_SVH
`define MATRIX4_INVERSE_ASSERT_SVH

// Same-cycle implication checked at every clock edge outside reset.
`define M4I_AST_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("m4inv: same-cycle check failed");

// Next-cycle implication checked at every clock edge outside reset.
`define M4I_AST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("m4inv: next-cycle check failed");

`endif

// ===== design/m4inv_pkg.sv =====
// Package with the item types, lane control type and sub-determinant and cofactor tables.
`timescale 1ns / 1ps
package m4inv_pkg;

  localparam int ELEM_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  typedef struct packed {
    logic [1:0]         row_index;
    logic signed [31:0] elem0;
    logic signed [31:0] elem1;
    logic signed [31:0] elem2;
    logic signed [31:0] elem3;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         out_row;
    logic signed [31:0] res0;
    logic signed [31:0] res1;
    logic signed [31:0] res2;
    logic signed [31:0] res3;
    logic               singular;
    logic               last_row;
  } out_item_t;

  typedef struct packed {
    logic       vld;
    logic       clr;
    logic       neg;
    logic       last;
    logic       top;
    logic [1:0] chunk;
  } mac_ctl_t;

  // Each 2x2 sub-determinant is e[p]*e[q] - e[r]*e[s].
  localparam logic [3:0] SUB_TAB [12][4] = '{
    '{4'd0, 4'd5, 4'd1, 4'd4}, '{4'd0, 4'd6, 4'd2, 4'd4}, '{4'd0, 4'd7, 4'd3, 4'd4},
    '{4'd1, 4'd6, 4'd2, 4'd5}, '{4'd1, 4'd7, 4'd3, 4'd5}, '{4'd2, 4'd7, 4'd3, 4'd6},
    '{4'd8, 4'd13, 4'd9, 4'd12}, '{4'd8, 4'd14, 4'd10, 4'd12},
    '{4'd8, 4'd15, 4'd11, 4'd12}, '{4'd9, 4'd14, 4'd10, 4'd13},
    '{4'd9, 4'd15, 4'd11, 4'd13}, '{4'd10, 4'd15, 4'd11, 4'd14}
  };

  // Each cofactor is three terms of element, sub-determinant and negate flag.
  localparam logic [3:0] COF_TAB [16][9] = '{
    '{4'd5, 4'd11, 4'd0, 4'd6, 4'd10, 4'd1, 4'd7, 4'd9, 4'd0},
    '{4'd2, 4'd10, 4'd0, 4'd1, 4'd11, 4'd1, 4'd3, 4'd9, 4'd1},
    '{4'd13, 4'd5, 4'd0, 4'd14, 4'd4, 4'd1, 4'd15, 4'd3, 4'd0},
    '{4'd10, 4'd4, 4'd0, 4'd9, 4'd5, 4'd1, 4'd11, 4'd3, 4'd1},
    '{4'd6, 4'd8, 4'd0, 4'd4, 4'd11, 4'd1, 4'd7, 4'd7, 4'd1},
    '{4'd0, 4'd11, 4'd0, 4'd2, 4'd8, 4'd1, 4'd3, 4'd7, 4'd0},
    '{4'd14, 4'd2, 4'd0, 4'd12, 4'd5, 4'd1, 4'd15, 4'd1, 4'd1},
    '{4'd8, 4'd5, 4'd0, 4'd10, 4'd2, 4'd1, 4'd11, 4'd1, 4'd0},
    '{4'd4, 4'd10, 4'd0, 4'd5, 4'd8, 4'd1, 4'd7, 4'd6, 4'd0},
    '{4'd1, 4'd8, 4'd0, 4'd0, 4'd10, 4'd1, 4'd3, 4'd6, 4'd1},
    '{4'd12, 4'd4, 4'd0, 4'd13, 4'd2, 4'd1, 4'd15, 4'd0, 4'd0},
    '{4'd9, 4'd2, 4'd0, 4'd8, 4'd4, 4'd1, 4'd11, 4'd0, 4'd1},
    '{4'd5, 4'd7, 4'd0, 4'd4, 4'd9, 4'd1, 4'd6, 4'd6, 4'd1},
    '{4'd0, 4'd9, 4'd0, 4'd1, 4'd7, 4'd1, 4'd2, 4'd6, 4'd0},
    '{4'd13, 4'd1, 4'd0, 4'd12, 4'd3, 4'd1, 4'd14, 4'd0, 4'd1},
    '{4'd8, 4'd3, 4'd0, 4'd9, 4'd1, 4'd1, 4'd10, 4'd0, 4'd0}
  };

endpackage

// ===== design/m4inv_lane.sv =====
// Multiply-accumulate lane: element times one chunk of a wide operand per cycle while ctl.vld is set.
`timescale 1ns / 1ps
module m4inv_lane import m4inv_pkg::*; #(
  parameter int EW = ELEM_WIDTH_DEF,
  parameter int AW = 4 * ELEM_WIDTH_DEF + 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mac_ctl_t             ctl,
  input  logic signed [EW-1:0] a,
  input  logic signed [AW-1:0] opnd,
  output logic signed [AW-1:0] acc,
  output logic                 done
);

  localparam int PW = 2 * EW + 1;

  logic [AW-1:0]        slice;
  logic signed [EW:0]   chunk_v;
  logic signed [PW-1:0] prod_nxt;
  logic signed [PW-1:0] prod_r;
  logic [AW-1:0]        term;
  logic [AW-1:0]        acc_nxt;
  logic signed [AW-1:0] acc_r;
  mac_ctl_t             ctl_r;
  logic                 done_r;

  always_comb begin
    slice    = opnd >> (ctl.chunk * EW);
    chunk_v  = {ctl.top & slice[EW], slice[EW-1:0]};
    prod_nxt = a * chunk_v;
    term     = AW'(prod_r) << (ctl_r.chunk * EW);
    acc_nxt  = (ctl_r.clr ? '0 : acc_r) + (term ^ {AW{ctl_r.neg}}) + AW'(ctl_r.neg);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r  <= '0;
      done_r <= 1'b0;
    end else begin
      ctl_r  <= ctl;
      done_r <= ctl_r.vld & ctl_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.vld) begin
      prod_r <= prod_nxt;
    end
    if (ctl_r.vld) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc  = acc_r;
  assign done = done_r;

endmodule

// ===== design/m4inv_div.sv =====
// Restoring divider: cofactor scaled by 2^(2*FB) over the determinant, saturated.
`timescale 1ns / 1ps
module m4inv_div import m4inv_pkg::*; #(
  parameter int EW  = ELEM_WIDTH_DEF,
  parameter int FB  = FRAC_BITS_DEF,
  parameter int CFW = 3 * ELEM_WIDTH_DEF + 2,
  parameter int AW  = 4 * ELEM_WIDTH_DEF + 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic signed [CFW-1:0] num,
  input  logic signed [AW-1:0]  den,
  output logic                  done,
  output logic signed [EW-1:0]  res
);

  localparam int NW = CFW + 2 * FB;
  localparam int MW = (NW > AW) ? NW : AW;
  localparam int CW = $clog2(EW + 2);
  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_CMP  = 2'd1;
  localparam logic [1:0] D_RUN  = 2'd2;
  localparam logic [1:0] D_FIN  = 2'd3;

  logic [1:0]           st_r;
  logic [CW-1:0]        cnt_r;
  logic                 done_r;
  logic [CFW-1:0]       num_mag;
  logic [AW-1:0]        den_mag;
  logic [NW-1:0]        nmag_r;
  logic [AW-1:0]        dmag_r;
  logic                 neg_r;
  logic                 ovf_r;
  logic [AW:0]          rem_r;
  logic [AW:0]          shifted;
  logic                 ge;
  logic [EW:0]          nlow_r;
  logic [EW:0]          q_r;
  logic [EW:0]          lim;
  logic [EW:0]          mag;
  logic signed [EW-1:0] res_r;

  always_comb begin
    num_mag = num[CFW-1] ? CFW'(-num) : CFW'(num);
    den_mag = den[AW-1] ? AW'(-den) : AW'(den);
    shifted = {rem_r[AW-1:0], nlow_r[EW]};
    ge      = shifted >= {1'b0, dmag_r};
    lim     = neg_r ? {2'b01, {(EW-1){1'b0}}} : {2'b00, {(EW-1){1'b1}}};
    mag     = (ovf_r || (q_r > lim)) ? lim : q_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= D_IDLE;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      case (st_r)
        D_IDLE: begin
          if (start) begin
            st_r <= D_CMP;
          end
        end
        D_CMP: begin
          cnt_r <= '0;
          st_r  <= D_RUN;
        end
        D_RUN: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CW'(EW)) begin
            st_r <= D_FIN;
          end
        end
        D_FIN: begin
          done_r <= 1'b1;
          st_r   <= D_IDLE;
        end
        default: st_r <= D_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      D_IDLE: begin
        nmag_r <= NW'(num_mag) << (2 * FB);
        dmag_r <= den_mag;
        neg_r  <= num[CFW-1] ^ den[AW-1];
      end
      D_CMP: begin
        ovf_r  <= MW'(nmag_r >> (EW + 1)) >= MW'(dmag_r);
        rem_r  <= (AW + 1)'(nmag_r >> (EW + 1));
        nlow_r <= nmag_r[EW:0];
        q_r    <= '0;
      end
      D_RUN: begin
        rem_r  <= ge ? (shifted - {1'b0, dmag_r}) : shifted;
        q_r    <= {q_r[EW-1:0], ge};
        nlow_r <= nlow_r << 1;
      end
      D_FIN: begin
        res_r <= EW'(neg_r ? -mag : mag);
      end
      default: begin
      end
    endcase
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

// ===== design/matrix4_inverse.sv =====
// Top level of the 4x4 fixed-point matrix inverse: row store, sequencer, lanes, dividers, merge.
//
// Input channel (in_valid/in_ready/in_data): one item carries one matrix row and its
// index. Rows 0 to 2 are stored and give no result. Row 3 stores the last row and
// starts the inversion; in_ready stays low until the inverse is out.
// Output channel (out_valid/out_ready/out_data): four items, inverse rows 0 to 3, the
// last one with last_row set. A zero determinant gives zero rows with singular set.
// Four lanes work side by side on twelve sub-determinants, then sixteen cofactors, then
// the determinant, which the merge adder tree completes. Each inverse row is then
// computed by the four restoring dividers, which make one quotient bit per cycle.
// A stalled receiver holds the output register; the sequencer waits before loading
// the next row, so nothing is lost. Reset is synchronous and empties the block; the
// matrix store holds no defined value until rows are written.
`timescale 1ns / 1ps
`include "matrix4_inverse_assert.svh"
module matrix4_inverse import m4inv_pkg::*; #(
  parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int EW  = ELEM_WIDTH;
  localparam int AW  = 4 * EW + 4;
  localparam int BW  = 2 * EW + 1;
  localparam int CFW = 3 * EW + 2;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MAC   = 3'd1;
  localparam logic [2:0] S_MERGE = 3'd2;
  localparam logic [2:0] S_DIVGO = 3'd3;
  localparam logic [2:0] S_DIVW  = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  localparam logic [1:0] PH_SUB = 2'd0;
  localparam logic [1:0] PH_COF = 2'd1;
  localparam logic [1:0] PH_DET = 2'd2;

  logic signed [EW-1:0]  elem_r [16];
  logic signed [BW-1:0]  b_r [12];
  logic signed [CFW-1:0] cof_r [16];
  logic signed [AW-1:0]  sum01_r;
  logic signed [AW-1:0]  sum23_r;
  logic signed [AW-1:0]  det_r;

  logic [2:0] st_r;
  logic [1:0] phase_r;
  logic [1:0] round_r;
  logic [1:0] term_r;
  logic [1:0] chunk_r;
  logic       wait_r;
  logic       sing_r;
  logic [1:0] n_rounds;
  logic [1:0] n_terms;
  logic [1:0] n_chunks;
  logic       out_load;
  logic       div_start;

  out_item_t  out_r;
  logic       out_valid_r;

  logic signed [AW-1:0] lane_acc [4];
  logic [3:0]           lane_done;
  logic signed [EW-1:0] div_res [4];
  logic [3:0]           div_done;

  assign in_ready  = (st_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_load  = (st_r == S_OUT) && (!out_valid_r || out_ready);
  assign div_start = (st_r == S_DIVGO) && (det_r != '0);

  always_comb begin
    case (phase_r)
      PH_SUB: begin
        n_rounds = 2'd2;
        n_terms  = 2'd1;
        n_chunks = 2'd0;
      end
      PH_COF: begin
        n_rounds = 2'd3;
        n_terms  = 2'd2;
        n_chunks = 2'd2;
      end
      default: begin
        n_rounds = 2'd0;
        n_terms  = 2'd0;
        n_chunks = 2'd3;
      end
    endcase
  end

  for (genvar l = 0; l < 4; l++) begin : g_lane
    logic [3:0]           k;
    logic [3:0]           ks;
    logic [3:0]           ti;
    logic [3:0]           bi;
    logic signed [EW-1:0] la;
    logic signed [AW-1:0] lo;
    mac_ctl_t             lc;

    always_comb begin
      k  = {round_r, 2'(l)};
      ks = (k > 4'd11) ? 4'd0 : k;
      ti = 4'(term_r) * 4'd3;
      bi = COF_TAB[k][ti + 4'd1];
      lc.vld   = (st_r == S_MAC) && !wait_r;
      lc.clr   = (term_r == 2'd0) && (chunk_r == 2'd0);
      lc.last  = (term_r == n_terms) && (chunk_r == n_chunks);
      lc.top   = (chunk_r == n_chunks);
      lc.chunk = chunk_r;
      case (phase_r)
        PH_SUB: begin
          la     = elem_r[SUB_TAB[ks][{term_r[0], 1'b0}]];
          lo     = AW'(elem_r[SUB_TAB[ks][{term_r[0], 1'b1}]]);
          lc.neg = term_r[0];
        end
        PH_COF: begin
          la     = elem_r[COF_TAB[k][ti]];
          lo     = AW'(b_r[(bi > 4'd11) ? 4'd0 : bi]);
          lc.neg = COF_TAB[k][ti + 4'd2][0];
        end
        default: begin
          la     = elem_r[4'(l)];
          lo     = AW'(cof_r[{2'(l), 2'b00}]);
          lc.neg = 1'b0;
        end
      endcase
    end

    m4inv_lane #(
      .EW(EW),
      .AW(AW)
    ) u_lane (
      .clk  (clk),
      .rst_n(rst_n),
      .ctl  (lc),
      .a    (la),
      .opnd (lo),
      .acc  (lane_acc[l]),
      .done (lane_done[l])
    );

    m4inv_div #(
      .EW (EW),
      .FB (FRAC_BITS),
      .CFW(CFW),
      .AW (AW)
    ) u_div (
      .clk  (clk),
      .rst_n(rst_n),
      .start(div_start),
      .num  (cof_r[k]),
      .den  (det_r),
      .done (div_done[l]),
      .res  (div_res[l])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      phase_r     <= PH_SUB;
      round_r     <= '0;
      term_r      <= '0;
      chunk_r     <= '0;
      wait_r      <= 1'b0;
      sing_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      case (st_r)
        S_IDLE: begin
          if (in_valid && in_ready && (in_data.row_index == 2'd3)) begin
            st_r    <= S_MAC;
            phase_r <= PH_SUB;
            round_r <= '0;
            term_r  <= '0;
            chunk_r <= '0;
            wait_r  <= 1'b0;
          end
        end
        S_MAC: begin
          if (!wait_r) begin
            if (chunk_r != n_chunks) begin
              chunk_r <= chunk_r + 1'b1;
            end else begin
              chunk_r <= '0;
              if (term_r != n_terms) begin
                term_r <= term_r + 1'b1;
              end else begin
                term_r <= '0;
                wait_r <= 1'b1;
              end
            end
          end else if (lane_done[0]) begin
            wait_r <= 1'b0;
            if (round_r != n_rounds) begin
              round_r <= round_r + 1'b1;
            end else begin
              round_r <= '0;
              case (phase_r)
                PH_SUB:  phase_r <= PH_COF;
                PH_COF:  phase_r <= PH_DET;
                default: st_r <= S_MERGE;
              endcase
            end
          end
        end
        S_MERGE: begin
          st_r <= S_DIVGO;
        end
        S_DIVGO: begin
          sing_r <= (det_r == '0);
          st_r   <= (det_r == '0) ? S_OUT : S_DIVW;
        end
        S_DIVW: begin
          if (div_done[0]) begin
            st_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_valid_r <= 1'b1;
            if (round_r == 2'd3) begin
              round_r <= '0;
              st_r    <= S_IDLE;
            end else begin
              round_r <= round_r + 1'b1;
              st_r    <= S_DIVGO;
            end
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      elem_r[{in_data.row_index, 2'd0}] <= in_data.elem0[EW-1:0];
      elem_r[{in_data.row_index, 2'd1}] <= in_data.elem1[EW-1:0];
      elem_r[{in_data.row_index, 2'd2}] <= in_data.elem2[EW-1:0];
      elem_r[{in_data.row_index, 2'd3}] <= in_data.elem3[EW-1:0];
    end
    if ((st_r == S_MAC) && wait_r && lane_done[0]) begin
      for (int l = 0; l < 4; l++) begin
        if (phase_r == PH_SUB) begin
          b_r[{round_r, 2'(l)}] <= BW'(lane_acc[l]);
        end
        if (phase_r == PH_COF) begin
          cof_r[{round_r, 2'(l)}] <= CFW'(lane_acc[l]);
        end
      end
      sum01_r <= lane_acc[0] + lane_acc[1];
      sum23_r <= lane_acc[2] + lane_acc[3];
    end
    if (st_r == S_MERGE) begin
      det_r <= sum01_r + sum23_r;
    end
    if (out_load) begin
      out_r.out_row  <= round_r;
      out_r.res0     <= sing_r ? '0 : 32'(div_res[0]);
      out_r.res1     <= sing_r ? '0 : 32'(div_res[1]);
      out_r.res2     <= sing_r ? '0 : 32'(div_res[2]);
      out_r.res3     <= sing_r ? '0 : 32'(div_res[3]);
      out_r.singular <= sing_r;
      out_r.last_row <= (round_r == 2'd3);
    end
  end

  `M4I_AST_IMPL(a_lanes_lockstep, lane_done[0], lane_done == 4'hF)
  `M4I_AST_IMPL(a_done_only_waiting, lane_done != 4'h0, (st_r == S_MAC) && wait_r)
  `M4I_AST_IMPL(a_singular_zero, out_valid_r && out_r.singular, (out_r.res0 == '0) && (out_r.res1 == '0) && (out_r.res2 == '0) && (out_r.res3 == '0))
  `M4I_AST_NEXT(a_last_row_idle, out_load && (round_r == 2'd3), (st_r == S_IDLE) && out_valid_r && out_r.last_row)

endmodule
